>>> src/lbb_pkg.sv
// ----------------------------------------------------------------------------
// lbb_pkg
// Shared types, constants and helpers for the line-buffered 3x3 blur filter.
// ----------------------------------------------------------------------------
package lbb_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned IDX_W      = 10;   // width of out_row / out_col
  localparam int unsigned CFG_DIM_W  = 11;   // width of the dimension registers
  localparam int unsigned DIM_W      = 13;   // holds any clamped dimension
  localparam int unsigned CFG_W      = 24;   // widest register
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned TAPS       = 3;
  localparam int unsigned PROD_W     = 2 * PIX_W;
  localparam int unsigned RSUM_W     = PROD_W + 2;
  localparam int unsigned SUM_W      = PROD_W + 4;
  localparam int unsigned DIV_SHIFT  = 4;    // divide by 16
  localparam int unsigned FIFO_DEPTH = 4;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

  localparam logic [CFG_DIM_W-1:0] DIM_RESET         = 11'd1024;
  localparam logic [CFG_W-1:0]     KERNEL_TOP_RESET  = 24'h010201;
  localparam logic [CFG_W-1:0]     KERNEL_MID_RESET  = 24'h020402;
  localparam logic [CFG_W-1:0]     KERNEL_BOT_RESET  = 24'h010201;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  typedef logic [TAPS-1:0][CFG_W-1:0] kernel_t;

  // per-output bookkeeping that rides along with a scan step
  typedef struct packed {
    logic             border;
    logic             frame_end;
    logic [IDX_W-1:0] orow;
    logic [IDX_W-1:0] ocol;
  } lbb_meta_t;

  // one classified scan step handed from the front to the back
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
    logic             pad_col;
    logic             emit;
    lbb_meta_t        meta;
  } lbb_item_t;

  // clamp a dimension register to [3, hi]
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v,
                                                 input int unsigned hi);
    logic [DIM_W-1:0] ext;
    logic [DIM_W-1:0] lim;
    ext = DIM_W'(v);
    lim = DIM_W'(hi);
    if (ext < DIM_W'(TAPS)) begin
      return DIM_W'(TAPS);
    end else if (ext > lim) begin
      return lim;
    end
    return ext;
  endfunction

endpackage

>>> src/line_buffered_3x3_blur.sv
// ----------------------------------------------------------------------------
// line_buffered_3x3_blur
// Streaming 3x3 convolution filter with line stores and configurable kernel.
// ----------------------------------------------------------------------------
// The block takes one scan step per clock and sustains that rate under
// continuous flow; a frame walks a (height+1) x (width+1) raster, the extra
// column and row being padding steps whose pixel is ignored. A step passes
// the front stage, where its line store RAM read completes, a four-entry
// queue, and then the window, product and row-sum stages into the output
// register that drives out_valid_o. The rate is set by the single line store
// RAM, which takes one read and one write each cycle. The line stores are not
// cleared after reset: the first two image rows fill them before any interior
// output reads them. Configuration is written through cfg_we_i / cfg_addr_i /
// cfg_wdata_i; the user must write it only while the block is idle, which the
// block itself does not enforce.
module line_buffered_3x3_blur #(
  parameter int unsigned MAX_WIDTH  = lbb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = lbb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lbb_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [lbb_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lbb_pkg::PIX_W-1:0]      pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lbb_pkg::PIX_W-1:0]      out_pixel_o,
  output logic [lbb_pkg::IDX_W-1:0]      out_row_o,
  output logic [lbb_pkg::IDX_W-1:0]      out_col_o,
  output logic                           frame_end_o
);
  import lbb_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);

  logic [CW-1:0] width_q;
  logic [RW-1:0] height_q;
  kernel_t       kernel_q;

  logic      push, full, fifo_valid, pop;
  lbb_item_t push_item, pop_item;

  // keep the dimensions already clamped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= CW'(clamp_dim(DIM_RESET, MAX_WIDTH));
      height_q    <= RW'(clamp_dim(DIM_RESET, MAX_HEIGHT));
      kernel_q[0] <= KERNEL_TOP_RESET;
      kernel_q[1] <= KERNEL_MID_RESET;
      kernel_q[2] <= KERNEL_BOT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_IMAGE_WIDTH:   width_q <= CW'(clamp_dim(cfg_wdata_i[CFG_DIM_W-1:0], MAX_WIDTH));
        REG_IMAGE_HEIGHT:  height_q <= RW'(clamp_dim(cfg_wdata_i[CFG_DIM_W-1:0], MAX_HEIGHT));
        REG_KERNEL_TOP:    kernel_q[0] <= cfg_wdata_i;
        REG_KERNEL_MIDDLE: kernel_q[1] <= cfg_wdata_i;
        REG_KERNEL_BOTTOM: kernel_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  lbb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .width_i    (width_q),
    .height_i   (height_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_i    (pixel_i),
    .push_o     (push),
    .item_o     (push_item),
    .full_i     (full)
  );

  lbb_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .data_o  (pop_item)
  );

  lbb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kernel_i    (kernel_q),
    .valid_i     (fifo_valid),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pixel_o (out_pixel_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .frame_end_o (frame_end_o)
  );

endmodule

>>> src/lbb_ram.sv
// ----------------------------------------------------------------------------
// lbb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lbb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold the last read while no new read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/lbb_front.sv
// ----------------------------------------------------------------------------
// lbb_front
// Scan position tracking, step classification and line store access. Both
// line stores share one RAM word: older line in the high byte, newer line in
// the low byte.
// ----------------------------------------------------------------------------
module lbb_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     width_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]    height_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [lbb_pkg::PIX_W-1:0]          pixel_i,
  output logic                               push_o,
  output lbb_pkg::lbb_item_t                 item_o,
  input  logic                               full_i
);
  import lbb_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic          accept;
  logic          pad_col, pad_row;

  logic             s1_valid_q, s1_valid_d;
  logic [PIX_W-1:0] s1_px_q;
  logic             s1_pad_col_q;
  logic             s1_emit_q;
  lbb_meta_t        s1_meta_q;
  logic [AW-1:0]    s1_addr_q;

  logic [2*PIX_W-1:0] rdata;
  logic [RW-1:0]      orow;
  logic [CW-1:0]      ocol;

  assign pad_col = col_q >= width_i;
  assign pad_row = row_q >= height_i;
  assign orow    = row_q - RW'(1);
  assign ocol    = col_q - CW'(1);

  assign push_o     = s1_valid_q && !full_i;
  assign in_ready_o = !s1_valid_q || push_o;
  assign accept     = in_valid_i && in_ready_o;

  // advance the scan position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (pad_col) begin
        col_d = '0;
        row_d = pad_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  assign s1_valid_d = accept ? 1'b1 : (push_o ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q             <= (pad_col || pad_row) ? '0 : pixel_i;
      s1_pad_col_q        <= pad_col;
      s1_emit_q           <= (row_q != '0) && (col_q != '0);
      s1_meta_q.border    <= (row_q == RW'(1)) || (col_q == CW'(1)) || pad_row || pad_col;
      s1_meta_q.frame_end <= pad_row && pad_col;
      s1_meta_q.orow      <= IDX_W'(orow);
      s1_meta_q.ocol      <= IDX_W'(ocol);
      s1_addr_q           <= col_q[AW-1:0];
    end
  end

  // read at acceptance, write back the shifted pair when the step moves on
  lbb_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (push_o && !s1_pad_col_q),
    .waddr_i (s1_addr_q),
    .wdata_i ({rdata[PIX_W-1:0], s1_px_q}),
    .re_i    (accept && !pad_col),
    .raddr_i (col_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    item_o         = '0;
    item_o.top     = rdata[2*PIX_W-1:PIX_W];
    item_o.mid     = rdata[PIX_W-1:0];
    item_o.bot     = s1_px_q;
    item_o.pad_col = s1_pad_col_q;
    item_o.emit    = s1_emit_q;
    item_o.meta    = s1_meta_q;
  end

endmodule

>>> src/lbb_fifo.sv
// ----------------------------------------------------------------------------
// lbb_fifo
// Short queue of classified scan steps between the front and the back.
// ----------------------------------------------------------------------------
module lbb_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lbb_pkg::lbb_item_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output lbb_pkg::lbb_item_t data_o
);
  import lbb_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  lbb_item_t       mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = count_q == NW'(DEPTH);
  assign valid_o = count_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + NW'(1);
        2'b01:   count_q <= count_q - NW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> src/lbb_back.sv
// ----------------------------------------------------------------------------
// lbb_back
// 3x3 window, nine-tap multiply-accumulate, divide by 16, saturation, border
// zeroing and the output register. Window, product, row-sum and output stages move together.
// ----------------------------------------------------------------------------
module lbb_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lbb_pkg::kernel_t          kernel_i,
  input  logic                      valid_i,
  input  lbb_pkg::lbb_item_t        item_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [lbb_pkg::PIX_W-1:0] out_pixel_o,
  output logic [lbb_pkg::IDX_W-1:0] out_row_o,
  output logic [lbb_pkg::IDX_W-1:0] out_col_o,
  output logic                      frame_end_o
);
  import lbb_pkg::*;

  logic adv;

  logic [TAPS-1:0][TAPS-1:0][PIX_W-1:0] win_q;

  logic      wv_q, pv_q, rv_q, ov_q;
  lbb_meta_t wmeta_q, pmeta_q, rmeta_q;

  logic [TAPS-1:0][TAPS-1:0][PROD_W-1:0] prod_d, prod_q;
  logic [TAPS-1:0][RSUM_W-1:0]           rsum_d, rsum_q;
  logic [SUM_W-1:0]                      total;
  logic [SUM_W-DIV_SHIFT-1:0]            quot;
  logic [PIX_W-1:0]                      pix_d;

  logic [PIX_W-1:0] opix_q;
  logic [IDX_W-1:0] orow_q, ocol_q;
  logic             oend_q;

  assign adv   = !ov_q || out_ready_i;
  assign pop_o = valid_i && adv;

  // shift the window left; a padding column keeps the right column
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < TAPS; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      if (!item_i.pad_col) begin
        win_q[0][2] <= item_i.top;
        win_q[1][2] <= item_i.mid;
        win_q[2][2] <= item_i.bot;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      for (int j = 0; j < TAPS; j++) begin
        prod_d[i][j] = PROD_W'(win_q[i][j]) * PROD_W'(kernel_i[i][j*PIX_W +: PIX_W]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      rsum_d[i] = RSUM_W'(prod_q[i][0]) + RSUM_W'(prod_q[i][1]) + RSUM_W'(prod_q[i][2]);
    end
  end

  assign total = SUM_W'(rsum_q[0]) + SUM_W'(rsum_q[1]) + SUM_W'(rsum_q[2]);
  assign quot  = total[SUM_W-1:DIV_SHIFT];

  always_comb begin
    if (rmeta_q.border) begin
      pix_d = '0;
    end else if (quot > (SUM_W-DIV_SHIFT)'(PIX_MAX)) begin
      pix_d = PIX_MAX;
    end else begin
      pix_d = quot[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q <= 1'b0;
      pv_q <= 1'b0;
      rv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      wv_q <= pop_o && item_i.emit;
      pv_q <= wv_q;
      rv_q <= pv_q;
      ov_q <= rv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wmeta_q <= item_i.meta;
      pmeta_q <= wmeta_q;
      prod_q  <= prod_d;
      rmeta_q <= pmeta_q;
      rsum_q  <= rsum_d;
      opix_q  <= pix_d;
      orow_q  <= rmeta_q.orow;
      ocol_q  <= rmeta_q.ocol;
      oend_q  <= rmeta_q.frame_end;
    end
  end

  assign out_valid_o = ov_q;
  assign out_pixel_o = opix_q;
  assign out_row_o   = orow_q;
  assign out_col_o   = ocol_q;
  assign frame_end_o = oend_q;

endmodule

>>> src/lbb_checker.sv
// ----------------------------------------------------------------------------
// lbb_checker
// Port-level checks for the blur filter, bound to the top level.
// ----------------------------------------------------------------------------
module lbb_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [lbb_pkg::PIX_W-1:0] out_pixel_o,
  input logic [lbb_pkg::IDX_W-1:0] out_row_o,
  input logic [lbb_pkg::IDX_W-1:0] out_col_o,
  input logic                      frame_end_o
);
  import lbb_pkg::*;

  // a stalled result stays offered
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(out_pixel_o) && $stable(out_row_o) && $stable(out_col_o) &&
      $stable(frame_end_o))
    else $error("stalled result changed");

  // first row and first column are border
  a_border_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_row_o == '0 || out_col_o == '0) |-> out_pixel_o == '0)
    else $error("border output not zero");

  // the last output of a frame sits on the bottom-right border
  a_frame_end_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> out_pixel_o == '0)
    else $error("frame end output not zero");

endmodule

bind line_buffered_3x3_blur lbb_checker u_lbb_checker (.*);

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line-buffered 3x3 blur filter. Whole frames are
// streamed through a valid/ready pixel port with random sender and receiver
// idling. A scoreboard class mirrors the line stores, the window and the scan
// position and checks every output transfer field by field. Configuration
// changes only at frame boundaries once the block has drained.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbb_pkg::*;

  localparam int unsigned CYCLE_LIMIT       = 1_000_000;
  localparam int unsigned SETTLE_CYCLES     = 24;
  localparam int unsigned MAX_GAP           = 10;
  localparam int unsigned HOLD_OFF_CYCLES   = 400;
  localparam int unsigned HOLD_OFF_AFTER    = 40;
  localparam int unsigned TARGET_ITEMS      = 1050;
  localparam int unsigned REPORT_LIMIT      = 10;
  localparam int unsigned LONG_LINE_WIDTH   = 60;
  localparam int unsigned TALL_IMAGE_HEIGHT = 40;

  typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_CHECKER} pix_mode_e;
  typedef enum int {KM_RANDOM, KM_SMALL, KM_BLUR, KM_ZERO, KM_FULL} kernel_mode_e;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } blur_out_t;

  class blur_scoreboard;
    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic [CFG_W-1:0]     kern [TAPS];
    logic [PIX_W-1:0]     older_line [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]     newer_line [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]     win [TAPS][TAPS];
    int unsigned          scan_row;
    int unsigned          scan_col;
    blur_out_t            pending_outputs [$];
    int unsigned          failures;
    int unsigned          results_seen;

    function new();
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      kern[0]    = KERNEL_TOP_RESET;
      kern[1]    = KERNEL_MID_RESET;
      kern[2]    = KERNEL_BOT_RESET;
      foreach (older_line[i]) older_line[i] = '0;
      foreach (newer_line[i]) newer_line[i] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      scan_row     = 0;
      scan_col     = 0;
      failures     = 0;
      results_seen = 0;
    endfunction

    function int unsigned eff_dim(logic [CFG_DIM_W-1:0] v, int unsigned hi);
      if (v < TAPS) return TAPS;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned active_width();
      return eff_dim(width_reg, MAX_WIDTH_DEF);
    endfunction

    function int unsigned active_height();
      return eff_dim(height_reg, MAX_HEIGHT_DEF);
    endfunction

    function int unsigned outstanding();
      return pending_outputs.size();
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
      case (addr)
        REG_IMAGE_WIDTH:   width_reg  = data[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT:  height_reg = data[CFG_DIM_W-1:0];
        REG_KERNEL_TOP:    kern[0]    = data;
        REG_KERNEL_MIDDLE: kern[1]    = data;
        REG_KERNEL_BOTTOM: kern[2]    = data;
        default: ;
      endcase
    endfunction

    function logic [PIX_W-1:0] blur_value();
      int unsigned acc;
      acc = 0;
      for (int i = 0; i < TAPS; i++) begin
        for (int j = 0; j < TAPS; j++) begin
          acc += 32'(win[i][j]) * 32'(kern[i][8*j +: 8]);
        end
      end
      acc = acc >> DIV_SHIFT;
      return (acc > 255) ? PIX_MAX : PIX_W'(acc);
    endfunction

    // advance the mirrored scan by one step and queue the output it produces
    function void note_pixel(logic [PIX_W-1:0] px_in);
      int unsigned w;
      int unsigned h;
      int unsigned row;
      int unsigned col;
      logic        pad_col;
      logic        pad_row;
      logic [PIX_W-1:0] px;
      blur_out_t   res;
      w       = active_width();
      h       = active_height();
      row     = scan_row;
      col     = scan_col;
      pad_col = (col >= w);
      pad_row = (row >= h);
      px      = (pad_col || pad_row) ? '0 : px_in;
      for (int i = 0; i < TAPS; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      // padding column keeps the right window column and leaves the stores alone
      if (!pad_col) begin
        win[0][2]       = older_line[col];
        win[1][2]       = newer_line[col];
        older_line[col] = newer_line[col];
        win[2][2]       = px;
        newer_line[col] = px;
      end
      if (row >= 1 && col >= 1) begin
        res.row  = IDX_W'(row - 1);
        res.col  = IDX_W'(col - 1);
        res.last = pad_row && pad_col;
        if (row - 1 == 0 || col - 1 == 0 || row - 1 >= h - 1 || col - 1 >= w - 1) begin
          res.value = '0;
        end else begin
          res.value = blur_value();
        end
        pending_outputs.push_back(res);
      end
      if (pad_col) begin
        scan_col = 0;
        scan_row = pad_row ? 0 : row + 1;
      end else begin
        scan_col = col + 1;
      end
    endfunction

    function void check_output(blur_out_t got);
      blur_out_t want;
      results_seen++;
      if (pending_outputs.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("%0t: unexpected output pix %0d row %0d col %0d end %0b",
                   $realtime, got.value, got.row, got.col, got.last);
        end
        return;
      end
      want = pending_outputs.pop_front();
      if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
          got.last !== want.last) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("%0t: mismatch exp pix %0d row %0d col %0d end %0b,",
                   $realtime, want.value, want.row, want.col, want.last,
                   " got pix %0d row %0d col %0d end %0b",
                   got.value, got.row, got.col, got.last);
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i  = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [PIX_W-1:0]      pixel_i     = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [PIX_W-1:0]      out_pixel_o;
  logic [IDX_W-1:0]      out_row_o;
  logic [IDX_W-1:0]      out_col_o;
  logic                  frame_end_o;

  blur_scoreboard sb;
  bit             tx_gaps     = 1'b1;
  bit             rx_gaps     = 1'b1;
  int unsigned    item_count  = 0;
  int unsigned    cycle_count = 0;

  line_buffered_3x3_blur uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pixel_o (out_pixel_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .frame_end_o (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("line_buffered_3x3_blur verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_output({out_pixel_o, out_row_o, out_col_o, frame_end_o});
    end
  end

  // receiver: random hold-offs, plus one long stall to back up the pipeline
  initial begin
    int unsigned gap;
    bit          held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && sb.results_seen >= HOLD_OFF_AFTER) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      gap = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic program_config(input logic [CFG_DIM_W-1:0] w, input logic [CFG_DIM_W-1:0] h,
                                input logic [CFG_W-1:0] kt, input logic [CFG_W-1:0] km,
                                input logic [CFG_W-1:0] kb);
    logic [CFG_ADDR_W-1:0] addr [5];
    logic [CFG_W-1:0]      data [5];
    addr[0] = REG_IMAGE_WIDTH;
    addr[1] = REG_IMAGE_HEIGHT;
    addr[2] = REG_KERNEL_TOP;
    addr[3] = REG_KERNEL_MIDDLE;
    addr[4] = REG_KERNEL_BOTTOM;
    // junk above the dimension field must be dropped
    data[0] = {(CFG_W - CFG_DIM_W)'($urandom), w};
    data[1] = {(CFG_W - CFG_DIM_W)'($urandom), h};
    data[2] = kt;
    data[3] = km;
    data[4] = kb;
    for (int i = 0; i < 5; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= addr[i];
      cfg_wdata_i <= data[i];
      @(posedge clk_i);
      sb.write_reg(addr[i], data[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] p, input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= p;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(p);
    item_count++;
  endtask

  task automatic run_frames(input int unsigned nframes, input pix_mode_e pm);
    int unsigned      w;
    int unsigned      h;
    logic [PIX_W-1:0] p;
    w = sb.active_width();
    h = sb.active_height();
    for (int f = 0; f < nframes; f++) begin
      for (int r = 0; r <= h; r++) begin
        for (int c = 0; c <= w; c++) begin
          case (pm)
            PIX_EXTREME: p = $urandom_range(0, 1) ? PIX_MAX : '0;
            // padding steps carry full scale, which must be ignored
            PIX_CHECKER: p = ((r + c) % 2 == 0 || r == h || c == w) ? PIX_MAX : '0;
            default:     p = PIX_W'($urandom_range(0, 255));
          endcase
          send_pixel(p, tx_gaps ? $urandom_range(0, MAX_GAP) : 0);
        end
      end
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CFG_W-1:0] kernel_row(input kernel_mode_e km, input int r);
    logic [CFG_W-1:0] row;
    case (km)
      KM_RANDOM: row = CFG_W'($urandom);
      KM_SMALL: begin
        row = '0;
        for (int j = 0; j < TAPS; j++) row[8*j +: 8] = 8'($urandom_range(0, 3));
      end
      KM_BLUR:   row = (r == 1) ? KERNEL_MID_RESET : ((r == 0) ? KERNEL_TOP_RESET
                                                              : KERNEL_BOT_RESET);
      KM_ZERO:   row = '0;
      default:   row = '1;
    endcase
    return row;
  endfunction

  task automatic random_phase();
    kernel_mode_e         km;
    pix_mode_e            pm;
    logic [CFG_DIM_W-1:0] w;
    logic [CFG_DIM_W-1:0] h;
    int unsigned          pick;
    pick = $urandom_range(0, 9);
    km = (pick < 2) ? KM_RANDOM : (pick < 6) ? KM_SMALL : (pick < 8) ? KM_BLUR :
         (pick < 9) ? KM_ZERO : KM_FULL;
    pick = $urandom_range(0, 9);
    w = (pick == 0) ? CFG_DIM_W'($urandom_range(0, 2)) :
        (pick == 1) ? CFG_DIM_W'($urandom_range(13, 40)) : CFG_DIM_W'($urandom_range(3, 12));
    pick = $urandom_range(0, 9);
    h = (pick == 0) ? CFG_DIM_W'($urandom_range(0, 2)) : CFG_DIM_W'($urandom_range(3, 8));
    pm = ($urandom_range(0, 4) == 0) ? PIX_EXTREME : PIX_RANDOM;
    tx_gaps = ($urandom_range(0, 3) != 0);
    rx_gaps = ($urandom_range(0, 3) != 0);
    program_config(w, h, kernel_row(km, 0), kernel_row(km, 1), kernel_row(km, 2));
    run_frames($urandom_range(1, 2), pm);
    wait_idle();
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // smallest frame, default blur, checkerboard with ignored padding
    program_config(CFG_DIM_W'(3), CFG_DIM_W'(3), KERNEL_TOP_RESET, KERNEL_MID_RESET,
                   KERNEL_BOT_RESET);
    run_frames(1, PIX_CHECKER);
    wait_idle();

    // dimensions below range clamp up, full-scale kernel saturates
    program_config(CFG_DIM_W'(0), CFG_DIM_W'(2), '1, '1, '1);
    run_frames(1, PIX_EXTREME);
    wait_idle();

    // long line with a continuous sender so the long stall backs up the input
    tx_gaps = 1'b0;
    program_config(CFG_DIM_W'(LONG_LINE_WIDTH), CFG_DIM_W'(1), kernel_row(KM_SMALL, 0),
                   kernel_row(KM_SMALL, 1), kernel_row(KM_SMALL, 2));
    run_frames(1, PIX_RANDOM);
    wait_idle();

    // taller image, width register below range
    tx_gaps = 1'b1;
    rx_gaps = 1'b0;
    program_config(CFG_DIM_W'(2), CFG_DIM_W'(TALL_IMAGE_HEIGHT), kernel_row(KM_SMALL, 0),
                   kernel_row(KM_SMALL, 1), kernel_row(KM_SMALL, 2));
    run_frames(1, PIX_RANDOM);
    wait_idle();

    while (item_count < TARGET_ITEMS) random_phase();

    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("line_buffered_3x3_blur verification clean");
    end else begin
      $display("line_buffered_3x3_blur verification failed");
    end
    $finish;
  end

endmodule
